FILE: design/lud_pkg.sv
// Package for the lens undistortion coordinate map.
// Holds the register index codes and the fixed field widths.
// Used by lens_undistort_coordinate_map; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lud_pkg;

  localparam int COORD_W = 11;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;
  localparam int CENTER_W = 20;
  localparam int FOCAL_W = 22;
  localparam int COEF_W = 24;

  // Register index codes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_FOCAL_X    = 3'd2,
    REG_FOCAL_Y    = 3'd3,
    REG_RADIAL_K1  = 3'd4,
    REG_RADIAL_K2  = 3'd5,
    REG_RADIAL_K3  = 3'd6,
    REG_TANGENTIAL = 3'd7
  } reg_index_t;

  localparam logic [CENTER_W-1:0] CENTER_RESET = 20'd262144;
  localparam logic [FOCAL_W-1:0] FOCAL_RESET = 22'd256000;

  // Quotient bits produced by the normalizing divider
  localparam int DIV_STEPS = 28;

endpackage

`default_nettype wire

FILE: design/lens_undistort_coordinate_map.sv
// Lens undistortion coordinate map: Brown-Conrady radial and tangential model.
// Top level; depends on lud_pkg.
`timescale 1ns / 1ps
`default_nettype none

// For each output pixel (dst_x, dst_y) the block returns the source pixel to
// sample and an in-bounds flag (0 means black, coordinates 0). One coordinate
// is accepted per clock and one result leaves per clock. The pipeline centers
// the coordinate, runs the pipelined restoring divider that normalizes by the
// focal length (one quotient bit per stage), then 11 stages of multiply, sum
// and back-projection. A stall at the output freezes the whole pipeline. The
// user must write registers through the cfg port only while no pixel is in
// flight; the block itself does not enforce this.
module lens_undistort_coordinate_map
  import lud_pkg::*;
#(
  parameter int IMAGE_WIDTH = 2048,
  parameter int IMAGE_HEIGHT = 2048
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [23:0]           s_tdata,   // dst_x [10:0], dst_y [21:11], zero pad
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [23:0]                m_tdata,   // src_x [10:0], src_y [21:11], zero pad
  output logic                       m_tuser,   // in_bounds
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LAST = DIV_STEPS + 11;
  localparam logic signed [39:0] U_LIMIT = 40'(IMAGE_WIDTH * 256);
  localparam logic signed [39:0] V_LIMIT = 40'(IMAGE_HEIGHT * 256);
  localparam logic signed [27:0] Q_MAX = 28'sh7FFFFFF;
  localparam logic signed [27:0] Q_MIN = -28'sh8000000;

  // Configuration registers
  logic [CENTER_W-1:0] center_x, center_y;
  logic [FOCAL_W-1:0]  focal_x, focal_y;
  logic [COEF_W-1:0]   radial_k1, radial_k2, radial_k3;
  logic [47:0]         tangential_pair;

  logic adv;
  logic [LAST:0] vld;

  assign cfg_ready = 1'b1;
  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Take a register write
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= CENTER_RESET;
      center_y <= CENTER_RESET;
      focal_x <= FOCAL_RESET;
      focal_y <= FOCAL_RESET;
      radial_k1 <= '0;
      radial_k2 <= '0;
      radial_k3 <= '0;
      tangential_pair <= '0;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_CENTER_X:   center_x <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:   center_y <= cfg_data[CENTER_W-1:0];
        REG_FOCAL_X:    focal_x <= cfg_data[FOCAL_W-1:0];
        REG_FOCAL_Y:    focal_y <= cfg_data[FOCAL_W-1:0];
        REG_RADIAL_K1:  radial_k1 <= cfg_data[COEF_W-1:0];
        REG_RADIAL_K2:  radial_k2 <= cfg_data[COEF_W-1:0];
        REG_RADIAL_K3:  radial_k3 <= cfg_data[COEF_W-1:0];
        REG_TANGENTIAL: tangential_pair <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective focal lengths (zero reads as one) and signed views of registers
  logic [FOCAL_W-1:0] fe_x, fe_y;
  logic signed [22:0] fs_x, fs_y;
  logic signed [20:0] cs_x, cs_y;
  logic signed [23:0] k1, k2, k3, p1, p2;

  assign fe_x = (focal_x == '0) ? 22'd1 : focal_x;
  assign fe_y = (focal_y == '0) ? 22'd1 : focal_y;
  assign fs_x = $signed({1'b0, fe_x});
  assign fs_y = $signed({1'b0, fe_y});
  assign cs_x = $signed({1'b0, center_x});
  assign cs_y = $signed({1'b0, center_y});
  assign k1 = $signed(radial_k1);
  assign k2 = $signed(radial_k2);
  assign k3 = $signed(radial_k3);
  assign p1 = $signed(tangential_pair[47:24]);
  assign p2 = $signed(tangential_pair[23:0]);

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], s_tvalid};
    end
  end

  // Center the coordinate and set up the divider
  logic signed [20:0] dx, dy;
  logic [19:0] ax, ay;
  logic ovx_in, ovy_in;

  assign dx = $signed({2'b00, s_tdata[10:0], 8'h00}) - cs_x;
  assign dy = $signed({2'b00, s_tdata[21:11], 8'h00}) - cs_y;
  assign ax = dx[20] ? 20'(-dx) : dx[19:0];
  assign ay = dy[20] ? 20'(-dy) : dy[19:0];
  assign ovx_in = {6'b0, ax} >= {fe_x, 4'b0};
  assign ovy_in = {6'b0, ay} >= {fe_y, 4'b0};

  logic [21:0] rem_x [0:DIV_STEPS];
  logic [21:0] rem_y [0:DIV_STEPS];
  logic [27:0] quo_x [0:DIV_STEPS];
  logic [27:0] quo_y [0:DIV_STEPS];
  logic [3:0]  low_x [0:DIV_STEPS];
  logic [3:0]  low_y [0:DIV_STEPS];
  logic        neg_x [0:DIV_STEPS];
  logic        neg_y [0:DIV_STEPS];
  logic        ovf_x [0:DIV_STEPS];
  logic        ovf_y [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_x[0] <= ovx_in ? '0 : {6'b0, ax[19:4]};
      rem_y[0] <= ovy_in ? '0 : {6'b0, ay[19:4]};
      quo_x[0] <= '0;
      quo_y[0] <= '0;
      low_x[0] <= ax[3:0];
      low_y[0] <= ay[3:0];
      neg_x[0] <= dx[20];
      neg_y[0] <= dy[20];
      ovf_x[0] <= ovx_in;
      ovf_y[0] <= ovy_in;
    end
  end

  // Restoring divider: one quotient bit per stage
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic nbx, nby, gex, gey;
    logic [22:0] tx, ty;

    assign nbx = (i < 4) ? low_x[i][3 - (i % 4)] : 1'b0;
    assign nby = (i < 4) ? low_y[i][3 - (i % 4)] : 1'b0;
    assign tx = {rem_x[i], nbx};
    assign ty = {rem_y[i], nby};
    assign gex = tx >= {1'b0, fe_x};
    assign gey = ty >= {1'b0, fe_y};

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_x[i+1] <= gex ? 22'(tx - {1'b0, fe_x}) : tx[21:0];
        rem_y[i+1] <= gey ? 22'(ty - {1'b0, fe_y}) : ty[21:0];
        quo_x[i+1] <= {quo_x[i][26:0], gex};
        quo_y[i+1] <= {quo_y[i][26:0], gey};
        low_x[i+1] <= low_x[i];
        low_y[i+1] <= low_y[i];
        neg_x[i+1] <= neg_x[i];
        neg_y[i+1] <= neg_y[i];
        ovf_x[i+1] <= ovf_x[i];
        ovf_y[i+1] <= ovf_y[i];
      end
    end
  end

  // Apply sign and saturate to Q4.24
  function automatic logic signed [27:0] sat_q(input logic [27:0] q, input logic neg,
                                                input logic ovf);
    logic signed [28:0] nq;
    begin
      nq = -$signed({1'b0, q});
      if (neg) begin
        if (ovf || q > 28'h8000000) sat_q = Q_MIN;
        else sat_q = nq[27:0];
      end else begin
        if (ovf || q[27]) sat_q = Q_MAX;
        else sat_q = $signed(q);
      end
    end
  endfunction

  logic signed [27:0] x_a, y_a;
  always_ff @(posedge clk) begin
    if (adv) begin
      x_a <= sat_q(quo_x[DIV_STEPS], neg_x[DIV_STEPS], ovf_x[DIV_STEPS]);
      y_a <= sat_q(quo_y[DIV_STEPS], neg_y[DIV_STEPS], ovf_y[DIV_STEPS]);
    end
  end

  // Squares and cross term
  logic signed [55:0] mxx, myy, mxy;
  assign mxx = x_a * x_a;
  assign myy = y_a * y_a;
  assign mxy = x_a * y_a;

  logic signed [27:0] x_b, y_b;
  logic signed [31:0] x2_b, y2_b, xy_b;
  always_ff @(posedge clk) begin
    if (adv) begin
      x_b <= x_a;
      y_b <= y_a;
      x2_b <= 32'(mxx >>> 24);
      y2_b <= 32'(myy >>> 24);
      xy_b <= 32'(mxy >>> 24);
    end
  end

  // r squared
  logic signed [32:0] r2sum;
  assign r2sum = 33'(x2_b) + 33'(y2_b);

  logic signed [27:0] x_c, y_c;
  logic signed [31:0] x2_c, y2_c, xy_c, r2_c;
  always_ff @(posedge clk) begin
    if (adv) begin
      x_c <= x_b;
      y_c <= y_b;
      x2_c <= x2_b;
      y2_c <= y2_b;
      xy_c <= xy_b;
      r2_c <= r2sum[32:31] != 2'b00 ? 32'sh7FFFFFFF : r2sum[31:0];
    end
  end

  // r to the fourth
  logic signed [63:0] m44;
  logic signed [39:0] r4w;
  assign m44 = r2_c * r2_c;
  assign r4w = 40'(m44 >>> 24);

  logic signed [27:0] x_d, y_d;
  logic signed [31:0] x2_d, y2_d, xy_d, r2_d, r4_d;
  always_ff @(posedge clk) begin
    if (adv) begin
      x_d <= x_c;
      y_d <= y_c;
      x2_d <= x2_c;
      y2_d <= y2_c;
      xy_d <= xy_c;
      r2_d <= r2_c;
      r4_d <= (r4w > 40'sh7FFFFFFF) ? 32'sh7FFFFFFF : r4w[31:0];
    end
  end

  // r to the sixth and tangential products
  logic signed [63:0] m66;
  logic signed [39:0] r6w;
  logic signed [33:0] sx, sy;
  logic signed [55:0] pxy1, pxy2;
  logic signed [57:0] pbx, pby;
  assign m66 = r4_d * r2_d;
  assign r6w = 40'(m66 >>> 24);
  assign sx = 34'(r2_d) + (34'(x2_d) <<< 1);
  assign sy = 34'(r2_d) + (34'(y2_d) <<< 1);
  assign pxy1 = p1 * xy_d;
  assign pxy2 = p2 * xy_d;
  assign pbx = p2 * sx;
  assign pby = p1 * sy;

  logic signed [27:0] x_e, y_e;
  logic signed [31:0] r2_e, r4_e, r6_e;
  logic signed [56:0] tax_e, tby_e;
  logic signed [57:0] tbx_e, tay_e;
  always_ff @(posedge clk) begin
    if (adv) begin
      x_e <= x_d;
      y_e <= y_d;
      r2_e <= r2_d;
      r4_e <= r4_d;
      r6_e <= (r6w > 40'sh7FFFFFFF) ? 32'sh7FFFFFFF : r6w[31:0];
      tax_e <= 57'(pxy1) <<< 1;
      tby_e <= 57'(pxy2) <<< 1;
      tbx_e <= pbx;
      tay_e <= pby;
    end
  end

  // Radial products and tangential sums
  logic signed [58:0] tsumx, tsumy;
  assign tsumx = 59'(tax_e) + 59'(tbx_e);
  assign tsumy = 59'(tay_e) + 59'(tby_e);

  logic signed [27:0] x_f, y_f;
  logic signed [55:0] kr1_f, kr2_f, kr3_f;
  logic signed [38:0] tsx_f, tsy_f;
  always_ff @(posedge clk) begin
    if (adv) begin
      x_f <= x_e;
      y_f <= y_e;
      kr1_f <= k1 * r2_e;
      kr2_f <= k2 * r4_e;
      kr3_f <= k3 * r6_e;
      tsx_f <= 39'(tsumx >>> 20);
      tsy_f <= 39'(tsumy >>> 20);
    end
  end

  // Radial factor
  logic signed [57:0] ksum;
  logic signed [38:0] radw;
  assign ksum = 58'(kr1_f) + 58'(kr2_f) + 58'(kr3_f);
  assign radw = 39'(ksum >>> 20) + 39'sd16777216;

  logic signed [27:0] x_g, y_g;
  logic signed [31:0] rad_g;
  logic signed [38:0] tsx_g, tsy_g;
  always_ff @(posedge clk) begin
    if (adv) begin
      x_g <= x_f;
      y_g <= y_f;
      if (radw > 39'sh7FFFFFFF) rad_g <= 32'sh7FFFFFFF;
      else if (radw < -39'sh80000000) rad_g <= -32'sh80000000;
      else rad_g <= radw[31:0];
      tsx_g <= tsx_f;
      tsy_g <= tsy_f;
    end
  end

  // Scale by the radial factor
  logic signed [59:0] mrx, mry;
  assign mrx = x_g * rad_g;
  assign mry = y_g * rad_g;

  logic signed [35:0] px_h, py_h;
  logic signed [38:0] tsx_h, tsy_h;
  always_ff @(posedge clk) begin
    if (adv) begin
      px_h <= 36'(mrx >>> 24);
      py_h <= 36'(mry >>> 24);
      tsx_h <= tsx_g;
      tsy_h <= tsy_g;
    end
  end

  // Distorted normalized coordinate
  logic signed [39:0] xdist_i, ydist_i;
  always_ff @(posedge clk) begin
    if (adv) begin
      xdist_i <= 40'(px_h) + 40'(tsx_h);
      ydist_i <= 40'(py_h) + 40'(tsy_h);
    end
  end

  // Project back to pixels
  logic signed [62:0] mfx, mfy;
  assign mfx = fs_x * xdist_i;
  assign mfy = fs_y * ydist_i;

  logic signed [39:0] ud_j, vd_j;
  always_ff @(posedge clk) begin
    if (adv) begin
      ud_j <= 40'(mfx >>> 24) + 40'(cs_x);
      vd_j <= 40'(mfy >>> 24) + 40'(cs_y);
    end
  end

  // Bounds check and output register
  logic inb;
  assign inb = !ud_j[39] && !vd_j[39] && (ud_j < U_LIMIT) && (vd_j < V_LIMIT);

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {2'b00, inb ? vd_j[18:8] : 11'd0, inb ? ud_j[18:8] : 11'd0};
      m_tuser <= inb;
    end
  end

  assign m_tvalid = vld[LAST];

endmodule

`default_nettype wire
